>>> src/dmwbc_pkg.sv
// Package for the direct-mapped write-back cache: geometry, action codes and
// the command record passed from front to back. No dependencies.
package dmwbc_pkg;

    localparam int CACHE_LINES  = 16;
    localparam int LINE_BYTES   = 16;
    localparam int MEMORY_LINES = 4096;

    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int LINE_W  = $clog2(CACHE_LINES);
    localparam int ADDR_W  = 16;
    localparam int TAG_W   = ADDR_W - OFF_W - LINE_W;
    localparam int MLINE_W = $clog2(MEMORY_LINES);
    localparam int DATA_W  = LINE_BYTES * 8;
    localparam int WORDS   = LINE_BYTES / 4;
    localparam int WSEL_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int QDEPTH  = 2;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    // Classified command kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;
    localparam logic [1:0] KIND_PRELOAD = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              misaligned;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] line;
        logic [WSEL_W-1:0] wsel;
        logic [MLINE_W-1:0] mline;
        logic [31:0]       wdata;
    } cmd_t;

    // Extract a word; word 0 occupies the most significant bits
    function automatic logic [31:0] get_word(input logic [DATA_W-1:0] d,
                                             input logic [WSEL_W-1:0] s);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < WORDS; i++)
            if (s == WSEL_W'(i))
                w = d[DATA_W-1-32*i -: 32];
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] put_word(input logic [DATA_W-1:0] d,
                                                   input logic [WSEL_W-1:0] s,
                                                   input logic [31:0] w);
        logic [DATA_W-1:0] r;
        r = d;
        for (int i = 0; i < WORDS; i++)
            if (s == WSEL_W'(i))
                r[DATA_W-1-32*i -: 32] = w;
        return r;
    endfunction

endpackage

>>> src/dmwbc_front.sv
// Front end: accepts commands, classifies them, and pushes them into a
// short queue. Depends on dmwbc_pkg.
module dmwbc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  logic [15:0]        address,
    input  logic [31:0]        write_word,
    output logic               busy,
    output logic               q_valid,
    output dmwbc_pkg::cmd_t    q_cmd,
    input  logic               q_pop
);

    localparam int PW = $clog2(dmwbc_pkg::QDEPTH);

    dmwbc_pkg::cmd_t q_reg [dmwbc_pkg::QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    dmwbc_pkg::cmd_t c;
    logic push;

    // Classify incoming command
    always_comb
    begin
        c.misaligned = address[1:0] != 2'b00;
        unique case (action)
            dmwbc_pkg::ACT_READ:    c.kind = dmwbc_pkg::KIND_READ;
            dmwbc_pkg::ACT_WRITE:   c.kind = dmwbc_pkg::KIND_WRITE;
            dmwbc_pkg::ACT_PRELOAD: c.kind = dmwbc_pkg::KIND_PRELOAD;
            default:                c.kind = dmwbc_pkg::KIND_NONE;
        endcase
        c.line  = address[dmwbc_pkg::OFF_W +: dmwbc_pkg::LINE_W];
        c.tag   = address[dmwbc_pkg::ADDR_W-1 -: dmwbc_pkg::TAG_W];
        c.wsel  = dmwbc_pkg::WSEL_W'(address[dmwbc_pkg::OFF_W-1:0] >> 2);
        c.mline = dmwbc_pkg::MLINE_W'(address >> dmwbc_pkg::OFF_W);
        c.wdata = write_word;
    end

    assign busy    = cnt_reg == (PW+1)'(dmwbc_pkg::QDEPTH);
    assign push    = start && !busy;
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = q_reg[rp_reg];

    // Store queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= c;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !push) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(dmwbc_pkg::QDEPTH)) else $error("count range");

endmodule

>>> src/dmwbc_back.sv
// Back end: tag lookup, writeback, fill and word access on the cache and
// the backing memory, with a clearing pass after reset. Depends on dmwbc_pkg.
module dmwbc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  dmwbc_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            done,
    output logic            status,
    output logic            hit,
    output logic [3:0]      line_index,
    output logic [31:0]     read_word
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int LW = dmwbc_pkg::LINE_W;
    localparam int MW = dmwbc_pkg::MLINE_W;
    localparam int DW = dmwbc_pkg::DATA_W;
    localparam int TW = dmwbc_pkg::TAG_W;

    logic [DW-1:0] mem [dmwbc_pkg::MEMORY_LINES];
    logic [DW-1:0] cdata_reg [dmwbc_pkg::CACHE_LINES];
    logic [TW-1:0] ctag_reg  [dmwbc_pkg::CACHE_LINES];
    logic [dmwbc_pkg::CACHE_LINES-1:0] valid_reg, dirty_reg;

    logic [2:0]    state_reg;
    logic [MW-1:0] clr_reg;
    dmwbc_pkg::cmd_t cmd_reg;
    logic [DW-1:0] mrd_reg;
    logic          hit_reg;

    logic          mem_we;
    logic [MW-1:0] mem_wa, mem_ra;
    logic [DW-1:0] mem_wd;
    logic [MW-1:0] victim_full;
    logic          cached_op;

    logic cur_hit;
    assign cur_hit = valid_reg[cmd_reg.line] && ctag_reg[cmd_reg.line] == cmd_reg.tag;
    assign victim_full = {ctag_reg[cmd_reg.line], cmd_reg.line};
    assign cached_op = !cmd_reg.misaligned
                       && (cmd_reg.kind == dmwbc_pkg::KIND_READ
                           || cmd_reg.kind == dmwbc_pkg::KIND_WRITE);

    // Backing memory port control
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cmd_reg.mline;
        mem_wd = '0;
        mem_ra = cmd_reg.mline;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
            end
            S_IDLE:
            begin
                // Read the line of the command being picked up
                if (q_valid)
                    mem_ra = q_cmd.mline;
            end
            S_LOOK:
            begin
                if (!cmd_reg.misaligned && cmd_reg.kind == dmwbc_pkg::KIND_PRELOAD)
                begin
                    mem_we = 1'b1;
                    mem_wd = dmwbc_pkg::put_word(mrd_reg, cmd_reg.wsel, cmd_reg.wdata);
                end
                else if (cached_op && !cur_hit && valid_reg[cmd_reg.line]
                         && dirty_reg[cmd_reg.line])
                begin
                    mem_we = 1'b1;
                    mem_wa = victim_full;
                    mem_wd = cdata_reg[cmd_reg.line];
                end
            end
            default: ;
        endcase
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mrd_reg <= mem[mem_ra];
    end

    // Cache data and tags
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR && clr_reg < MW'(dmwbc_pkg::CACHE_LINES))
        begin
            cdata_reg[LW'(clr_reg)] <= '0;
            ctag_reg[LW'(clr_reg)]  <= '0;
        end
        else if (state_reg == S_FILL)
        begin
            if (!hit_reg)
            begin
                ctag_reg[cmd_reg.line] <= cmd_reg.tag;
                if (cmd_reg.kind == dmwbc_pkg::KIND_WRITE)
                    cdata_reg[cmd_reg.line] <=
                        dmwbc_pkg::put_word(mrd_reg, cmd_reg.wsel, cmd_reg.wdata);
                else
                    cdata_reg[cmd_reg.line] <= mrd_reg;
            end
            else if (cmd_reg.kind == dmwbc_pkg::KIND_WRITE)
                cdata_reg[cmd_reg.line] <= dmwbc_pkg::put_word(
                    cdata_reg[cmd_reg.line], cmd_reg.wsel, cmd_reg.wdata);
        end
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            hit_reg   <= 1'b0;
            cmd_reg   <= '0;
            done      <= 1'b0;
            status    <= 1'b0;
            hit       <= 1'b0;
            line_index <= '0;
            read_word <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == MW'(dmwbc_pkg::MEMORY_LINES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_reg <= cur_hit;
                    if (cmd_reg.misaligned || cmd_reg.kind == dmwbc_pkg::KIND_NONE
                        || cmd_reg.kind == dmwbc_pkg::KIND_PRELOAD)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    valid_reg[cmd_reg.line] <= 1'b1;
                    if (cmd_reg.kind == dmwbc_pkg::KIND_WRITE)
                        dirty_reg[cmd_reg.line] <= 1'b1;
                    else if (!hit_reg)
                        dirty_reg[cmd_reg.line] <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done       <= 1'b1;
                    status     <= cmd_reg.misaligned;
                    hit        <= !cmd_reg.misaligned && hit_reg
                                  && (cmd_reg.kind == dmwbc_pkg::KIND_READ
                                      || cmd_reg.kind == dmwbc_pkg::KIND_WRITE);
                    line_index <= 4'(cmd_reg.line);
                    if (cmd_reg.misaligned || cmd_reg.kind == dmwbc_pkg::KIND_NONE)
                        read_word <= '0;
                    else if (cmd_reg.kind == dmwbc_pkg::KIND_READ)
                        read_word <= dmwbc_pkg::get_word(cdata_reg[cmd_reg.line],
                                                         cmd_reg.wsel);
                    else
                        read_word <= cmd_reg.wdata;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign q_pop = state_reg == S_IDLE && q_valid;

    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE) else $error("stray strobe");
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |=> valid_reg[cmd_reg.line]) else $error("fill lost");
    a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0) else $error("dirty without valid");

endmodule

>>> src/direct_mapped_writeback_cache_top.sv
// Top level of the direct-mapped write-back cache: joins the front end and
// the back end. Depends on dmwbc_pkg, dmwbc_front and dmwbc_back.
//
// Usage: drive action, address and write_word with start; the command is
// taken on a clock edge where start is high and busy is low. A two-entry
// queue holds commands while the back end works, so busy rises only when it
// is full. Each command yields one result on status, hit, line_index and
// read_word, shown for exactly one cycle with done high; the receiver
// cannot stall it. A cached read or write passes through the back end as
// pick up, lookup with writeback, fill or update, and result; a preload,
// misaligned or unknown command skips the fill or update step. The backing
// memory has a registered read: a line is read before it is merged or
// filled. After reset the back end sweeps the backing memory to zero;
// commands queue up meanwhile.
module direct_mapped_writeback_cache_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] address,
    input  logic [31:0] write_word,
    output logic        done,
    output logic        status,
    output logic        hit,
    output logic [3:0]  line_index,
    output logic [31:0] read_word
);

    logic            q_valid, q_pop;
    dmwbc_pkg::cmd_t q_cmd;

    dmwbc_front u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .address(address), .write_word(write_word), .busy(busy),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    dmwbc_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_pop(q_pop), .done(done), .status(status), .hit(hit),
        .line_index(line_index), .read_word(read_word)
    );

endmodule

>>> test/tb_top.sv
// Testbench for direct_mapped_writeback_cache_top: random and directed word
// reads, writes, preloads and undefined actions checked against an in-bench cache model.
// Depends on dmwbc_pkg and the cache RTL.
module tb_top;

    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [31:0] wdata;
    } cmd_item_t;

    typedef struct {
        logic        status;
        logic        hit;
        logic [3:0]  line;
        logic [31:0] word;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [15:0] address;
    logic [31:0] write_word;
    logic        done;
    logic        status;
    logic        hit;
    logic [3:0]  line_index;
    logic [31:0] read_word;

    cmd_item_t     pending_cmds[$];
    cache_result_t expected_results[$];
    int            error_count;
    int            send_idle_pct;
    bit            hold_for_drain;

    // Cache shadow state
    bit          shadow_valid[16];
    bit          shadow_dirty[16];
    logic [7:0]  shadow_tag[16];
    logic [127:0] shadow_line[16];
    logic [127:0] shadow_mem[4096];

    direct_mapped_writeback_cache_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .address    (address),
        .write_word (write_word),
        .done       (done),
        .status     (status),
        .hit        (hit),
        .line_index (line_index),
        .read_word  (read_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Compute the expected result of one command and update the shadow state
    function automatic cache_result_t predict_cache_access(cmd_item_t c);
        cache_result_t r;
        logic [3:0]  ln;
        logic [7:0]  tg;
        logic [1:0]  ws;
        logic [11:0] ml;
        r.status = 1'b0;
        r.hit = 1'b0;
        r.word = '0;
        ln = c.addr[7:4];
        tg = c.addr[15:8];
        ws = c.addr[3:2];
        ml = c.addr[15:4];
        r.line = ln;
        if (c.addr[1:0] != 2'b00)
        begin
            r.status = 1'b1;
        end
        else if (c.act == dmwbc_pkg::ACT_PRELOAD)
        begin
            shadow_mem[ml][127-32*ws -: 32] = c.wdata;
            r.word = c.wdata;
        end
        else if (c.act == dmwbc_pkg::ACT_READ || c.act == dmwbc_pkg::ACT_WRITE)
        begin
            r.hit = shadow_valid[ln] && shadow_tag[ln] == tg;
            if (!r.hit)
            begin
                if (shadow_valid[ln] && shadow_dirty[ln])
                    shadow_mem[{shadow_tag[ln], ln}] = shadow_line[ln];
                shadow_line[ln] = shadow_mem[ml];
                shadow_valid[ln] = 1'b1;
                shadow_dirty[ln] = 1'b0;
                shadow_tag[ln] = tg;
            end
            if (c.act == dmwbc_pkg::ACT_READ)
            begin
                r.word = shadow_line[ln][127-32*ws -: 32];
            end
            else
            begin
                shadow_line[ln][127-32*ws -: 32] = c.wdata;
                shadow_dirty[ln] = 1'b1;
                r.word = c.wdata;
            end
        end
        return r;
    endfunction

    // Drive commands; predict at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            action <= '0;
            address <= '0;
            write_word <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                cmd_item_t c;
                c.act = action;
                c.addr = address;
                c.wdata = write_word;
                expected_results.push_back(predict_cache_access(c));
            end
            if (!(start && busy))
            begin
                if (pending_cmds.size() > 0 && !hold_for_drain &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_item_t n;
                    n = pending_cmds.pop_front();
                    start <= 1'b1;
                    action <= n.act;
                    address <= n.addr;
                    write_word <= n.wdata;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                cache_result_t e;
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0h actual %0h", e.status, status);
                    error_count++;
                end
                if (hit !== e.hit)
                begin
                    $error("hit expected %0h actual %0h", e.hit, hit);
                    error_count++;
                end
                if (line_index !== e.line)
                begin
                    $error("line_index expected %0h actual %0h", e.line, line_index);
                    error_count++;
                end
                if (read_word !== e.word)
                begin
                    $error("read_word expected %0h actual %0h", e.word, read_word);
                    error_count++;
                end
            end
        end
    end

    function automatic cmd_item_t make_cmd(logic [1:0] a, logic [15:0] ad, logic [31:0] w);
        cmd_item_t c;
        c.act = a;
        c.addr = ad;
        c.wdata = w;
        return c;
    endfunction

    // Random command: mostly aligned, tags drawn from a few values for reuse
    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            c.act = dmwbc_pkg::ACT_READ;
        else if (sel < 80)
            c.act = dmwbc_pkg::ACT_WRITE;
        else if (sel < 95)
            c.act = dmwbc_pkg::ACT_PRELOAD;
        else
            c.act = ACT_UNDEFINED;
        c.addr = 16'($urandom);
        if ($urandom_range(99) < 75)
            c.addr[15:8] = 8'($urandom_range(3) * 8'h55);
        if ($urandom_range(99) < 90)
            c.addr[1:0] = 2'b00;
        c.wdata = $urandom;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = 35;
        hold_for_drain = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_tag[i] = '0;
            shadow_line[i] = '0;
        end
        for (int i = 0; i < 4096; i++)
            shadow_mem[i] = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: miss, hit, dirty eviction, preload, misaligned, unknown action
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'h0000, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_WRITE, 16'h0004, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'h0004, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_PRELOAD, 16'hFFFC, 32'hDEAD_BEEF));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'hFFFC, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_WRITE, 16'hFFF0, 32'h1234_5678));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'h0FF0, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'hFFF0, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_PRELOAD, 16'hFFF8, 32'hA5A5_5A5A));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'hFFF8, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_WRITE, 16'h0001, 32'h1111_1111));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'h0002, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_PRELOAD, 16'hFFFF, 32'h2222_2222));
        pending_cmds.push_back(make_cmd(ACT_UNDEFINED, 16'h1234, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(ACT_UNDEFINED, 16'hABC8, 32'h0));
        pending_cmds.push_back(make_cmd(dmwbc_pkg::ACT_READ, 16'h0000, 32'h0));

        // Random phases: sender idles, then bursts
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 55 : 0;
            for (int i = 0; i < 460; i++)
                pending_cmds.push_back(random_cmd());
            wait_drained();
            // Hold off once until everything has come back
            if (ph == 0)
            begin
                hold_for_drain = 1'b1;
                repeat (20) @(posedge clk);
                hold_for_drain = 1'b0;
            end
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("direct_mapped_writeback_cache_top test passed");
        else
            $display("direct_mapped_writeback_cache_top test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("direct_mapped_writeback_cache_top test failed");
        $finish;
    end
endmodule
